[hw/rtl/q8dq_pkg.sv]
package q8dq_pkg;

	localparam int QMAX_W = 28;
	localparam int ROWB_W = 13;
	localparam int CFG_IDX_W = 8;
	localparam logic [ROWB_W-1:0] ROW_MAX = 13'd4096;
	localparam logic [QMAX_W-1:0] QMAX_RESET = 28'd134217727;
	localparam logic [ROWB_W-1:0] ROWB_RESET = 13'd64;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_Q_MAX = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_BLOCKS = 8'd1;

	// moduli and the integer-indefinite code
	localparam logic [63:0] MOD_M1 = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] MOD_M2 = 64'h0000_0000_7FFF_FFED;
	localparam logic [63:0] INT64_INDEF = 64'h8000_0000_0000_0000;

	// configuration write as seen by the front and back
	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [QMAX_W-1:0]    data;
	} cfg_wr_t;

	// classified item passed from front to back
	typedef struct packed {
		logic        is_scale;
		logic [15:0] data;
		logic        last_blk;
		logic        last_row;
	} item_t;

	// unpacked fp32 gain of the current block
	typedef struct packed {
		logic              sign;
		logic signed [7:0] exp;
		logic [23:0]       mant;
		logic              zero;
		logic              special;
	} gain_t;

endpackage

[hw/rtl/q8dq_fifo.sv]
module q8dq_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  q8dq_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output q8dq_pkg::item_t head_item
);
	import q8dq_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	item_t           mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item = mem_q[rd_ptr_q];

	// store on push
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue occupancy above depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty queue");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");

endmodule

[hw/rtl/q8dq_front.sv]
module q8dq_front #(
	parameter int BLOCK_ELEMENTS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  q8dq_pkg::cfg_wr_t cfg,
	input  logic [7:0]        in_byte,
	input  logic              in_accept,
	output logic              push,
	output q8dq_pkg::item_t   push_item
);
	import q8dq_pkg::*;

	localparam int PW = $clog2(BLOCK_ELEMENTS + 2);
	localparam logic [PW-1:0] POS_LAST = PW'(BLOCK_ELEMENTS + 1);
	localparam logic [PW-1:0] POS_HI = PW'(1);

	logic [PW-1:0]     pos_q;
	logic [7:0]        lo_q;
	logic [11:0]       blk_q;
	logic [ROWB_W-1:0] row_blocks_q;
	logic [ROWB_W-1:0] lim;
	logic              last_blk;
	logic              last_row;

	// clamp row length
	always_comb begin
		if (row_blocks_q == '0) lim = ROWB_W'(1);
		else if (row_blocks_q > ROW_MAX) lim = ROW_MAX;
		else lim = row_blocks_q;
	end

	assign last_blk = (pos_q == POS_LAST);
	assign last_row = last_blk && (({1'b0, blk_q} + 13'd1) >= lim);

	// classify the byte
	assign push = in_accept && (pos_q != '0);
	always_comb begin
		push_item.is_scale = (pos_q == POS_HI);
		push_item.data = (pos_q == POS_HI) ? {in_byte, lo_q} : {8'd0, in_byte};
		push_item.last_blk = last_blk;
		push_item.last_row = last_row;
	end

	// track stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			lo_q <= '0;
			blk_q <= '0;
			row_blocks_q <= ROWB_RESET;
		end else begin
			if (cfg.valid && cfg.index == CFG_ROW_BLOCKS) begin
				row_blocks_q <= cfg.data[ROWB_W-1:0];
			end
			if (in_accept) begin
				if (pos_q == '0) lo_q <= in_byte;
				if (last_blk) begin
					pos_q <= '0;
					blk_q <= last_row ? 12'd0 : blk_q + 12'd1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

[hw/rtl/q8dq_back.sv]
module q8dq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  q8dq_pkg::cfg_wr_t cfg,
	input  logic              head_valid,
	input  q8dq_pkg::item_t   head_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       out_m1,
	output logic [31:0]       out_m2,
	output logic              out_lb,
	output logic              out_lr
);
	import q8dq_pkg::*;

	logic              en;
	logic [QMAX_W-1:0] q_max_q;
	logic [23:0]       qf_m_q;
	logic [4:0]        qf_e_q;
	logic              qf_zero_q;
	gain_t             gain_q;

	// stage registers
	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	item_t             it_s1;
	logic              sc_s2, lb_s2, lr_s2, sg_s2, zr_s2, sp_s2, qs_s2;
	logic [34:0]       p_s2;
	logic signed [7:0] es_s2;
	logic [7:0]        a_s2;
	logic [31:0]       p_s3;
	logic signed [7:0] e_s3, k_s4;
	logic              sg_s3, zr_s3, sp_s3, lb_s3, lr_s3;
	logic [23:0]       n_s4;
	logic              sg_s4, zr_s4, sp_s4, lb_s4, lr_s4;
	logic [63:0]       x_s5, x_s6, r1_s7, r2_s7;
	logic              lb_s5, lr_s5, lb_s6, lr_s6, lb_s7, lr_s7;
	logic [31:0]       m1_s8, m2_s8;
	logic              lb_s8, lr_s8;

	assign en = !v_s8 || out_ready;
	assign pop = en && head_valid;

	// q_max to fp32, round to nearest even
	logic [4:0]        ql;
	logic [2:0]        qsh;
	logic [QMAX_W-1:0] qn, qrem, qhalf;
	logic [24:0]       qn25;
	logic [23:0]       qm_c;
	logic [4:0]        qe_c;
	always_comb begin
		ql = '0;
		for (int i = 0; i < QMAX_W; i++) begin
			if (q_max_q[i]) ql = 5'(i);
		end
		qsh = '0;
		qn = '0;
		qrem = '0;
		qhalf = '0;
		qn25 = '0;
		if (ql <= 5'd23) begin
			qm_c = 24'(q_max_q << (5'd23 - ql));
			qe_c = ql;
		end else begin
			qsh = 3'(ql - 5'd23);
			qn = q_max_q >> qsh;
			qrem = q_max_q & ~({QMAX_W{1'b1}} << qsh);
			qhalf = QMAX_W'(1) << (qsh - 3'd1);
			qn25 = {1'b0, qn[23:0]} +
				25'((qrem > qhalf) || (qrem == qhalf && qn[0]));
			if (qn25[24]) begin
				qm_c = 24'h800000;
				qe_c = ql + 5'd1;
			end else begin
				qm_c = qn25[23:0];
				qe_c = ql;
			end
		end
	end

	// hold config and its fp32 form
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_max_q <= QMAX_RESET;
			qf_m_q <= '0;
			qf_e_q <= '0;
			qf_zero_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.index == CFG_Q_MAX) q_max_q <= cfg.data;
			qf_m_q <= qm_c;
			qf_e_q <= qe_c;
			qf_zero_q <= (q_max_q == '0);
		end
	end

	// stage 2: decode half scale, multiply mantissas
	logic [4:0]        he;
	logic [9:0]        hm;
	logic [3:0]        hp;
	logic [10:0]       m11;
	logic signed [7:0] eu;
	always_comb begin
		he = it_s1.data[14:10];
		hm = it_s1.data[9:0];
		hp = '0;
		for (int i = 0; i < 10; i++) begin
			if (hm[i]) hp = 4'(i);
		end
		if (he == 5'd0) begin
			m11 = 11'(hm) << (4'd10 - hp);
			eu = $signed({4'd0, hp}) - 8'sd24;
		end else begin
			m11 = {1'b1, hm};
			eu = $signed({3'd0, he}) - 8'sd15;
		end
	end

	// stage 3: round gain; quants multiply by gain
	logic [23:0] gn;
	logic        gup;
	logic [24:0] gn25;
	logic signed [7:0] ge;
	always_comb begin
		if (p_s2[34]) begin
			gn = p_s2[34:11];
			gup = p_s2[10] && ((|p_s2[9:0]) || gn[0]);
			ge = es_s2 + 8'sd1;
		end else begin
			gn = p_s2[33:10];
			gup = p_s2[9] && ((|p_s2[8:0]) || gn[0]);
			ge = es_s2;
		end
		gn25 = {1'b0, gn} + 25'(gup);
	end

	// stage 4: normalize and round the fp32 product
	logic [3:0]  l2;
	logic [3:0]  sh2;
	logic [31:0] n2, rem2, half2;
	logic [24:0] n2r;
	always_comb begin
		l2 = '0;
		for (int i = 23; i < 32; i++) begin
			if (p_s3[i]) l2 = 4'(i - 23);
		end
		sh2 = l2;
		n2 = p_s3 >> sh2;
		rem2 = p_s3 & ~(32'hFFFF_FFFF << sh2);
		half2 = (sh2 != '0) ? (32'd1 << (sh2 - 4'd1)) : 32'd0;
		n2r = {1'b0, n2[23:0]} +
			25'((sh2 != '0) && ((rem2 > half2) || (rem2 == half2 && n2[0])));
	end

	// stage 5: convert to int64, ties to even
	logic [5:0]  s5;
	logic [23:0] q5, rem5, half5;
	logic [63:0] mag;
	always_comb begin
		s5 = 6'(-k_s4);
		q5 = '0;
		rem5 = '0;
		half5 = '0;
		if (!k_s4[7]) begin
			mag = {40'd0, n_s4} << k_s4[5:0];
		end else if (s5 >= 6'd25) begin
			mag = '0;
		end else begin
			q5 = n_s4 >> s5;
			rem5 = n_s4 & ~(24'hFF_FFFF << s5);
			half5 = 24'd1 << (s5 - 6'd1);
			mag = {40'd0, q5} + 64'((rem5 > half5) || (rem5 == half5 && q5[0]));
		end
	end

	// stage 7 and output compares, signed 64-bit
	logic [63:0] r1a, r2a;
	assign r1a = (x_s6 & MOD_M1) + (x_s6 >> 31);
	assign r2a = (!x_s6[63] && x_s6 >= MOD_M2) ? x_s6 - MOD_M2 : x_s6;

	logic [63:0] r1f, r2f;
	assign r1f = (!r1_s7[63] && r1_s7 >= MOD_M1) ? r1_s7 - MOD_M1 : r1_s7;
	assign r2f = (!r2_s7[63] && r2_s7 >= MOD_M2) ? r2_s7 - MOD_M2 : r2_s7;

	// advance valid bits and the block gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			gain_q <= '{sign: 1'b0, exp: 8'sd0, mant: 24'd0, zero: 1'b1, special: 1'b0};
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && !sc_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			if (v_s2 && sc_s2) begin
				gain_q.sign <= sg_s2;
				gain_q.zero <= zr_s2;
				gain_q.special <= sp_s2;
				if (gn25[24]) begin
					gain_q.mant <= 24'h800000;
					gain_q.exp <= ge + 8'sd1;
				end else begin
					gain_q.mant <= gn25[23:0];
					gain_q.exp <= ge;
				end
			end
		end
	end

	// move payload down the pipe
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= head_item;

			sc_s2 <= it_s1.is_scale;
			lb_s2 <= it_s1.last_blk;
			lr_s2 <= it_s1.last_row;
			sg_s2 <= it_s1.data[15];
			sp_s2 <= (he == 5'h1F);
			zr_s2 <= (he == 5'd0 && hm == '0) || qf_zero_q;
			p_s2 <= 35'(m11) * 35'(qf_m_q);
			es_s2 <= eu + $signed({3'd0, qf_e_q});
			qs_s2 <= it_s1.data[7];
			a_s2 <= it_s1.data[7] ? 8'(~it_s1.data[7:0] + 8'd1) : it_s1.data[7:0];

			p_s3 <= 32'(gain_q.mant) * 32'(a_s2);
			e_s3 <= gain_q.exp;
			sg_s3 <= gain_q.sign ^ qs_s2;
			sp_s3 <= gain_q.special;
			zr_s3 <= gain_q.zero || (a_s2 == '0);
			lb_s3 <= lb_s2;
			lr_s3 <= lr_s2;

			n_s4 <= n2r[24] ? 24'h800000 : n2r[23:0];
			k_s4 <= e_s3 - 8'sd23 + $signed({4'd0, sh2}) + $signed({7'd0, n2r[24]});
			sg_s4 <= sg_s3;
			sp_s4 <= sp_s3;
			zr_s4 <= zr_s3;
			lb_s4 <= lb_s3;
			lr_s4 <= lr_s3;

			if (sp_s4) x_s5 <= INT64_INDEF;
			else if (zr_s4) x_s5 <= '0;
			else x_s5 <= sg_s4 ? (64'd0 - mag) : mag;
			lb_s5 <= lb_s4;
			lr_s5 <= lr_s4;

			x_s6 <= x_s5[63] ? x_s5 + MOD_M1 : x_s5;
			lb_s6 <= lb_s5;
			lr_s6 <= lr_s5;

			r1_s7 <= r1a;
			r2_s7 <= r2a;
			lb_s7 <= lb_s6;
			lr_s7 <= lr_s6;

			m1_s8 <= r1f[31:0];
			m2_s8 <= r2f[31:0];
			lb_s8 <= lb_s7;
			lr_s8 <= lr_s7;
		end
	end

	assign out_valid = v_s8;
	assign out_m1 = m1_s8;
	assign out_m2 = m2_s8;
	assign out_lb = lb_s8;
	assign out_lr = lr_s8;

endmodule

[hw/rtl/q8_dequant_crt_residue_split_top.sv]
// Q8_0 dequantizer with residue split modulo 2^31-1 and 2^31-19.
// An accepted quant byte passes the queue and stage registers s1 to s8 before its result shows on m_tvalid.
// Throughput: one byte per cycle while the queue is not full (s_tready high); scale bytes give no result.
// A 4-entry queue parts the byte classifier from the 8-stage math pipe.
// Reset (arst_n low, asynchronous) clears position, gain and queue, and
// loads q_max = 134217727 and row_blocks = 64.
module q8_dequant_crt_residue_split_top #(
	parameter int BLOCK_ELEMENTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] raw_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] residue_m1, [63:32] residue_m2
	output logic        m_tuser,   // [0] last_in_block
	output logic        m_tlast,   // last_in_row
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [27:0] cfg_data
);
	import q8dq_pkg::*;

	cfg_wr_t     cfg;
	logic        push;
	item_t       push_item;
	logic        full;
	logic        pop;
	logic        head_valid;
	item_t       head_item;
	logic [31:0] res_m1;
	logic [31:0] res_m2;

	assign cfg_ready = 1'b1;
	assign cfg = '{valid: cfg_valid, index: cfg_index, data: cfg_data};
	assign s_tready = !full;

	q8dq_front #(.BLOCK_ELEMENTS(BLOCK_ELEMENTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_byte   (s_tdata),
		.in_accept (s_tvalid && s_tready),
		.push      (push),
		.push_item (push_item)
	);

	q8dq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	q8dq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_m1     (res_m1),
		.out_m2     (res_m2),
		.out_lb     (m_tuser),
		.out_lr     (m_tlast)
	);

	assign m_tdata = {res_m2, res_m1};

endmodule

[tb/sv/q8_dequant_crt_residue_split_top_tb.sv]
module q8_dequant_crt_residue_split_top_tb;
	import q8dq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUANTS = 32;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;
	localparam logic [31:0] F32_NAN = 32'h7FC0_0000;
	localparam logic [31:0] F32_INF = 32'h7F80_0000;

	typedef struct {
		logic [31:0] res_m1;
		logic [31:0] res_m2;
		logic        blk_end;
		logic        row_end;
	} residue_t;

	// Bit-exact predictor of the dequantizer and its expected residues
	class dequant_scoreboard;
		logic [27:0] gain_ceiling;
		logic [12:0] row_len;
		int          byte_pos;
		logic [7:0]  scale_lo;
		logic [31:0] gain_bits;
		int          blk_idx;
		residue_t    residue_q[$];
		int          mismatches;
		int          results_seen;
		int          indef_seen;
		int          rows_seen;

		function new();
			gain_ceiling = QMAX_RESET;
			row_len = ROWB_RESET;
			byte_pos = 0;
			scale_lo = 0;
			gain_bits = 0;
			blk_idx = 0;
			mismatches = 0;
			results_seen = 0;
			indef_seen = 0;
			rows_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [27:0] val);
			if (idx == CFG_Q_MAX) gain_ceiling = val;
			else if (idx == CFG_ROW_BLOCKS) row_len = val[12:0];
		endfunction

		// fp16 to fp32, subnormals normalized
		function logic [31:0] half_to_f32(logic [15:0] h);
			logic [31:0] sgn;
			logic [7:0]  ex;
			logic [9:0]  m;
			logic [10:0] mm;
			sgn = {h[15], 31'd0};
			m = h[9:0];
			if (h[14:10] == 5'd0) begin
				if (m == 0) return sgn;
				ex = 8'd113;
				mm = {1'b0, m};
				while (mm[10] == 1'b0) begin
					mm = mm << 1;
					ex = ex - 8'd1;
				end
				return sgn | {1'b0, ex, mm[9:0], 13'd0};
			end
			if (h[14:10] == 5'h1F) return sgn | F32_INF | {9'd0, m, 13'd0};
			return sgn | {1'b0, 8'(h[14:10] + 8'd112), m, 13'd0};
		endfunction

		// unsigned integer to fp32, ties to even
		function logic [31:0] uint_to_f32(logic [31:0] n);
			int sh;
			int msb;
			logic [31:0] q;
			logic [31:0] rem;
			logic [31:0] half;
			sh = 0;
			while ((n >> sh) >= 32'h0100_0000) sh++;
			if (sh > 0) begin
				q = n >> sh;
				rem = n & ((32'd1 << sh) - 1);
				half = 32'd1 << (sh - 1);
				if (rem > half || (rem == half && q[0])) q++;
				n = q << sh;
			end
			if (n == 0) return 32'd0;
			msb = 31;
			while (!n[msb]) msb--;
			if (msb <= 23) n = n << (23 - msb);
			else n = n >> (msb - 23);
			return {1'b0, 8'(127 + msb), n[22:0]};
		endfunction

		// fp32 multiply, ties to even; operands are never subnormal here
		function logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
			logic        sgn;
			logic [47:0] p;
			logic [47:0] rem;
			logic [47:0] half;
			logic [24:0] q;
			int          ex;
			int          sh;
			sgn = a[31] ^ b[31];
			if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
				if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
					return F32_NAN;
				if (a[30:23] == 8'd0 || b[30:23] == 8'd0) return F32_NAN;
				return {sgn, 31'd0} | F32_INF;
			end
			if (a[30:23] == 8'd0 || b[30:23] == 8'd0) return {sgn, 31'd0};
			p = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
			ex = int'(a[30:23]) + int'(b[30:23]) - 127;
			if (p[47]) begin
				sh = 24;
				ex++;
			end else begin
				sh = 23;
			end
			q = 25'(p >> sh);
			rem = p & ((48'd1 << sh) - 1);
			half = 48'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0])) q++;
			if (q[24]) begin
				q = q >> 1;
				ex++;
			end
			if (ex >= 255) return {sgn, 31'd0} | F32_INF;
			return {sgn, 8'(ex), q[22:0]};
		endfunction

		// fp32 to int64, ties to even, indefinite on NaN or overflow
		function logic [63:0] f32_to_i64(logic [31:0] b);
			int          ex;
			int          sh;
			logic [63:0] m;
			logic [63:0] q;
			logic [63:0] rem;
			logic [63:0] half;
			ex = int'(b[30:23]);
			m = {40'd0, 1'b1, b[22:0]};
			if (ex >= 190) return INT64_INDEF;
			if (ex == 0) return 64'd0;
			if (ex >= 150) begin
				q = m << (ex - 150);
			end else begin
				sh = 150 - ex;
				if (sh >= 26) return 64'd0;
				q = m >> sh;
				rem = m & ((64'd1 << sh) - 1);
				half = 64'd1 << (sh - 1);
				if (rem > half || (rem == half && q[0])) q++;
			end
			return b[31] ? -q : q;
		endfunction

		function bit ge_signed(logic [63:0] a, logic [63:0] m);
			return !a[63] && a >= m;
		endfunction

		// Advance the predictor by one accepted byte
		function void note_byte(logic [7:0] raw);
			logic [31:0] qf;
			logic [63:0] x;
			logic [63:0] r1;
			logic [63:0] r2;
			int          lim;
			residue_t    e;
			if (byte_pos == 0) begin
				scale_lo = raw;
				byte_pos = 1;
				return;
			end
			if (byte_pos == 1) begin
				gain_bits = f32_mul(half_to_f32({raw, scale_lo}), uint_to_f32({4'd0, gain_ceiling}));
				byte_pos = 2;
				return;
			end
			qf = uint_to_f32(raw[7] ? 32'(9'd256 - raw) : {24'd0, raw});
			qf[31] = raw[7];
			x = f32_to_i64(f32_mul(qf, gain_bits));
			if (x == INT64_INDEF) indef_seen++;
			if (x[63]) x = x + MOD_M1;
			r1 = (x & MOD_M1) + (x >> 31);
			if (ge_signed(r1, MOD_M1)) r1 = r1 - MOD_M1;
			r2 = x;
			if (ge_signed(r2, MOD_M2)) r2 = r2 - MOD_M2;
			if (ge_signed(r2, MOD_M2)) r2 = r2 - MOD_M2;
			e.res_m1 = r1[31:0];
			e.res_m2 = r2[31:0];
			e.blk_end = (byte_pos == QUANTS + 1);
			e.row_end = 1'b0;
			if (e.blk_end) begin
				lim = (row_len == 0) ? 1 : ((row_len > ROW_MAX) ? int'(ROW_MAX) : int'(row_len));
				if (blk_idx + 1 >= lim) begin
					e.row_end = 1'b1;
					blk_idx = 0;
				end else begin
					blk_idx++;
				end
				byte_pos = 0;
			end else begin
				byte_pos++;
			end
			residue_q.push_back(e);
		endfunction

		// Compare one output transfer against the oldest expectation
		function void check_result(logic [63:0] tdata, logic tuser, logic tlast);
			residue_t e;
			results_seen++;
			if (residue_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: m1=%h m2=%h blk=%b row=%b",
						tdata[31:0], tdata[63:32], tuser, tlast);
				return;
			end
			e = residue_q.pop_front();
			if (e.row_end) rows_seen++;
			if (tdata[31:0] !== e.res_m1 || tdata[63:32] !== e.res_m2 ||
				tuser !== e.blk_end || tlast !== e.row_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp m1=%h m2=%h blk=%b row=%b, got m1=%h m2=%h blk=%b row=%b",
						e.res_m1, e.res_m2, e.blk_end, e.row_end,
						tdata[31:0], tdata[63:32], tuser, tlast);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [27:0] cfg_data;

	dequant_scoreboard sb = new();
	int burst_left = 0;
	int stall_pct = 0;
	int stall_span = 0;
	int bytes_sent = 0;
	int phases_run = 0;

	q8_dequant_crt_residue_split_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the receiver in spans of varying pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_span <= 0;
			stall_pct <= 0;
		end else begin
			if (stall_span == 0) begin
				stall_span <= $urandom_range(20, 300);
				case ($urandom_range(0, 3))
					0: stall_pct <= 0;
					1: stall_pct <= 30;
					2: stall_pct <= 70;
					default: stall_pct <= 95;
				endcase
			end else begin
				stall_span <= stall_span - 1;
			end
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Check every output transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	// Send one byte, then idle for a random gap at the end of a burst
	task automatic send_byte(logic [7:0] raw);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= raw;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(raw);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Hold until every expected result has arrived and the pipe is empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.residue_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Drop valid after each write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [27:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_phase(logic [27:0] ceiling, logic [27:0] row);
		wait_drained();
		write_reg(CFG_Q_MAX, ceiling);
		write_reg(CFG_ROW_BLOCKS, row);
		phases_run++;
	endtask

	// Random stream; scale high bytes lean toward infinity and NaN
	task automatic send_random(int count);
		logic [7:0] raw;
		repeat (count) begin
			raw = 8'($urandom);
			if (sb.byte_pos == 1 && $urandom_range(0, 7) == 0) raw[6:2] = 5'h1F;
			send_byte(raw);
		end
	endtask

	task automatic send_block(logic [15:0] scale, logic [7:0] q0, logic [7:0] q1);
		send_byte(scale[7:0]);
		send_byte(scale[15:8]);
		send_byte(q0);
		send_byte(q1);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h00);
		repeat (QUANTS - 6) send_byte(8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: infinite and NaN scales at reset settings, then subnormal and largest scales
		send_block(16'hFC00, 8'h00, 8'h01);
		send_block(16'h7E00, 8'h01, 8'h81);
		set_phase(28'hFFF_FFFF, 28'd2);
		write_reg(CFG_UNUSED, 28'h123_4567);
		send_block(16'h0001, 8'h01, 8'h81);
		send_block(16'h7BFF, 8'h81, 8'h01);
		send_block(16'h8400, 8'h7F, 8'h01);

		// Random phases over the register extremes
		set_phase(28'd1, 28'd1);
		send_random(220);
		set_phase(28'd0, 28'd0);
		send_random(150);
		set_phase(28'd16777217, 28'd8191);
		send_random(200);
		set_phase(28'hFFF_FFFF, 28'd4096);
		send_random(200);
		set_phase(28'($urandom_range(1, 28'hFFF_FFFF)), 28'd4097);
		send_random(200);
		set_phase(28'($urandom_range(1, 28'hFFF_FFFF)), 28'($urandom_range(1, 5)));
		send_random(250);
		// Shorten the row while it is under way
		set_phase(QMAX_RESET, 28'd3);
		send_random(100);
		set_phase(28'($urandom_range(1, 1000)), 28'd1);
		send_random(100);

		wait_drained();
		$display("Sent %0d bytes over %0d register settings; %0d results checked,",
			bytes_sent, phases_run, sb.results_seen);
		$display("%0d indefinite conversions, %0d row ends, %0d mismatches",
			sb.indef_seen, sb.rows_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.residue_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
